// ===== rtl/core/mbqf_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter package
// Shared constants, register indexes and pipeline control types.
// ----------------------------------------------------------------------------
package mbqf_pkg;

   localparam int COEF_WIDTH      = 26;
   localparam int FRAC_BITS       = 20;
   localparam int CHANNEL_WIDTH   = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_STAGES      = 4;
   localparam int OUT_DEPTH       = 8;
   localparam int OUT_PTR_WIDTH   = 3;
   localparam int OUT_CNT_WIDTH   = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic                     valid;
      logic                     in_range;
      logic [CHANNEL_WIDTH-1:0] channel;
   } stage_tag_type;

endpackage

// ===== rtl/core/mbqf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbqf_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mbqf_mac.sv =====
// ----------------------------------------------------------------------------
// Biquad multiply-accumulate pipeline
// Four stages: input and history read, products, partial sums, rounded accumulator with saturation.
// ----------------------------------------------------------------------------
module mbqf_mac
   import mbqf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stage_tag_type                 in_tag,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  logic                          hist_valid,
   input  logic [4*SAMPLE_WIDTH-1:0]     hist_data,
   input  coef_set_type                  coefs,
   output stage_tag_type                 stage_tags [NUM_STAGES],
   output logic [SAMPLE_WIDTH-1:0]       y_out,
   output logic                          clip_out,
   output logic [4*SAMPLE_WIDTH-1:0]     wb_data
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int PROD_W  = COEF_WIDTH + SW;
   localparam int ACC_W   = PROD_W + 3;
   localparam int SHIFT_W = ACC_W - FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SHIFT_W-1:0] SAT_MAX =
      {{(SHIFT_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [SHIFT_W-1:0] SAT_MIN =
      {{(SHIFT_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

   stage_tag_type tag_ff [NUM_STAGES];
   stage_tag_type tag_in [NUM_STAGES];

   logic signed [SW-1:0] x_s1_ff, x_s2_ff, x_s3_ff, x_s4_ff;
   logic signed [SW-1:0] x1_s2_ff, x1_s3_ff, x1_s4_ff;
   logic signed [SW-1:0] y1_s2_ff, y1_s3_ff, y1_s4_ff;

   logic [4*SW-1:0]          hist;
   logic signed [SW-1:0]     hx1, hx2, hy1, hy2;
   logic signed [PROD_W-1:0] prod_in [5];
   logic signed [PROD_W-1:0] prod_ff [5];
   logic signed [ACC_W-1:0]  sum_ff_in, sum_fb_in, sum_ff_ff, sum_fb_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic signed [SHIFT_W-1:0] shifted;
   logic                     clip_hi, clip_lo;

   assign hist = hist_valid ? hist_data : '0;
   assign hx1  = hist[SW-1:0];
   assign hx2  = hist[2*SW-1:SW];
   assign hy1  = hist[3*SW-1:2*SW];
   assign hy2  = hist[4*SW-1:3*SW];

   always_comb begin
      prod_in[0] = PROD_W'(coefs.b0) * PROD_W'(x_s1_ff);
      prod_in[1] = PROD_W'(coefs.b1) * PROD_W'(hx1);
      prod_in[2] = PROD_W'(coefs.b2) * PROD_W'(hx2);
      prod_in[3] = PROD_W'(coefs.a1) * PROD_W'(hy1);
      prod_in[4] = PROD_W'(coefs.a2) * PROD_W'(hy2);
      sum_ff_in  = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2]);
      sum_fb_in  = ACC_W'(prod_ff[3]) + ACC_W'(prod_ff[4]);
      acc_in     = sum_ff_ff - sum_fb_ff + HALF;
   end

   always_comb begin
      tag_in[0] = in_tag;
      for (int i = 1; i < NUM_STAGES; i++) begin
         tag_in[i] = tag_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            tag_ff[i] <= tag_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_s1_ff   <= in_sample;
      prod_ff   <= prod_in;
      x_s2_ff   <= x_s1_ff;
      x1_s2_ff  <= hx1;
      y1_s2_ff  <= hy1;
      sum_ff_ff <= sum_ff_in;
      sum_fb_ff <= sum_fb_in;
      x_s3_ff   <= x_s2_ff;
      x1_s3_ff  <= x1_s2_ff;
      y1_s3_ff  <= y1_s2_ff;
      acc_ff    <= acc_in;
      x_s4_ff   <= x_s3_ff;
      x1_s4_ff  <= x1_s3_ff;
      y1_s4_ff  <= y1_s3_ff;
   end

   assign shifted = acc_ff[ACC_W-1:FRAC_BITS];
   assign clip_hi = shifted > SAT_MAX;
   assign clip_lo = shifted < SAT_MIN;

   always_comb begin
      if (!tag_ff[NUM_STAGES-1].in_range) begin
         y_out    = '0;
         clip_out = 1'b0;
      end else if (clip_hi) begin
         y_out    = SAT_MAX[SW-1:0];
         clip_out = 1'b1;
      end else if (clip_lo) begin
         y_out    = SAT_MIN[SW-1:0];
         clip_out = 1'b1;
      end else begin
         y_out    = shifted[SW-1:0];
         clip_out = 1'b0;
      end
   end

   assign wb_data    = {y1_s4_ff, y_out, x1_s4_ff, x_s4_ff};
   assign stage_tags = tag_ff;

endmodule

// ===== rtl/core/mbqf_out_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that holds finished results until the sink takes them.
// ----------------------------------------------------------------------------
module mbqf_out_queue
   import mbqf_pkg::*;
#(
   parameter int WIDTH = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0]         slot_ff [OUT_DEPTH];
   logic [OUT_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + OUT_CNT_WIDTH'(push) - OUT_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/multichannel_biquad_filter.sv =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter
// Direct form I second-order section shared over several channels, with the
// per-channel history held in one RAM entry per channel.
//
//   Channel  Direction  Ports                       Payload
//   req      in         req_tvalid/tready/tdata     sample_in; tuser: channel
//   rsp      out        rsp_tvalid/tready/tdata     sample_out; tuser: channel_out,
//                                                   clipped
//   csr      in         csr_valid/ready             csr_index, csr_data
//
// One sample is accepted per cycle while the result queue has room and each
// sample's channel differs from those of the four samples before it. A sample
// waits until an earlier sample of the same channel has written its history
// back, so samples of one channel never overlap in the pipeline. A beat's
// result reaches rsp through the MAC pipeline and then the result queue. Reset
// clears the history at once through per-channel valid bits. With a stalled
// sink, req_tready drops once eight beats are outstanding.
module multichannel_biquad_filter
   import mbqf_pkg::*;
#(
   parameter int CHANNELS     = 8,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,  // sample_in
   input  logic [CHANNEL_WIDTH-1:0]              req_tuser,  // channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     rsp_tdata,  // sample_out
   output logic [CHANNEL_WIDTH:0]                rsp_tuser,  // channel_out, clipped
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]            csr_index,
   input  logic [COEF_WIDTH-1:0]                 csr_data
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int TDATA_W = ((SW + 7) / 8) * 8;
   localparam int AW      = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
   localparam int HIST_W  = 4 * SW;
   localparam int RES_W   = CHANNEL_WIDTH + SW + 1;

   coef_set_type  coefs_ff;
   stage_tag_type in_tag;
   stage_tag_type stage_tags [NUM_STAGES];

   logic [CHANNELS-1:0]      hvalid_ff;
   logic                     hist_valid_ff;
   logic [OUT_CNT_WIDTH-1:0] occ_ff, occ_in;
   logic                     hazard, accept, pop, wb_en;
   logic [AW-1:0]            rd_addr, wb_addr;
   logic [HIST_W-1:0]        rd_data, wb_data;
   logic [SW-1:0]            y_out;
   logic                     clip_out;
   logic [RES_W-1:0]         res_data;
   logic                     req_in_range;

   assign req_in_range = 32'(req_tuser) < CHANNELS;

   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (stage_tags[i].valid && stage_tags[i].in_range
             && stage_tags[i].channel == req_tuser) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_tready = (occ_ff < OUT_CNT_WIDTH'(OUT_DEPTH)) && !hazard;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign occ_in     = occ_ff + OUT_CNT_WIDTH'(accept) - OUT_CNT_WIDTH'(pop);

   assign rd_addr = AW'(req_tuser);
   assign wb_addr = AW'(stage_tags[NUM_STAGES-1].channel);
   assign wb_en   = stage_tags[NUM_STAGES-1].valid && stage_tags[NUM_STAGES-1].in_range;

   always_comb begin
      in_tag.valid    = accept;
      in_tag.in_range = req_in_range;
      in_tag.channel  = req_tuser;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         hvalid_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         if (wb_en) begin
            hvalid_ff[wb_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hist_valid_ff <= hvalid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0 <= COEF_WIDTH'(1) << FRAC_BITS;
         coefs_ff.b1 <= '0;
         coefs_ff.b2 <= '0;
         coefs_ff.a1 <= '0;
         coefs_ff.a2 <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_B0:  coefs_ff.b0 <= csr_data;
            CSR_B1:  coefs_ff.b1 <= csr_data;
            CSR_B2:  coefs_ff.b2 <= csr_data;
            CSR_A1:  coefs_ff.a1 <= csr_data;
            CSR_A2:  coefs_ff.a2 <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   mbqf_ram #(
      .WIDTH(HIST_W),
      .DEPTH(CHANNELS)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (wb_en),
      .wr_addr(wb_addr),
      .wr_data(wb_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mbqf_mac #(
      .SAMPLE_WIDTH(SW)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (in_tag),
      .in_sample (req_tdata[SW-1:0]),
      .hist_valid(hist_valid_ff),
      .hist_data (rd_data),
      .coefs     (coefs_ff),
      .stage_tags(stage_tags),
      .y_out     (y_out),
      .clip_out  (clip_out),
      .wb_data   (wb_data)
   );

   mbqf_out_queue #(
      .WIDTH(RES_W)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (stage_tags[NUM_STAGES-1].valid),
      .push_data({clip_out, y_out, stage_tags[NUM_STAGES-1].channel}),
      .pop      (pop),
      .out_valid(rsp_tvalid),
      .out_data (res_data)
   );

   assign rsp_tuser = {res_data[RES_W-1], res_data[CHANNEL_WIDTH-1:0]};
   assign rsp_tdata = TDATA_W'(res_data[CHANNEL_WIDTH+SW-1:CHANNEL_WIDTH]);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OUT_CNT_WIDTH'(OUT_DEPTH))
      else $error("result credit count exceeds queue depth");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> !((stage_tags[0].valid && stage_tags[0].in_range
                   && stage_tags[0].channel == stage_tags[NUM_STAGES-1].channel)
               || (stage_tags[1].valid && stage_tags[1].in_range
                   && stage_tags[1].channel == stage_tags[NUM_STAGES-1].channel)
               || (stage_tags[2].valid && stage_tags[2].in_range
                   && stage_tags[2].channel == stage_tags[NUM_STAGES-1].channel)))
      else $error("two samples of one channel in flight together");

   a_rsp_backed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("result shown without an outstanding beat");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      accept |=> occ_ff <= OUT_CNT_WIDTH'(OUT_DEPTH))
      else $error("beat accepted without queue room");

endmodule

// ===== tb/multichannel_biquad_filter_checker.sv =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter checker
// Watches the sample, result and coefficient channels of the filter. For every
// accepted sample beat it computes the filtered sample from its own copy of the
// coefficients and the per-channel history. It then compares each result beat,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_checker
   import mbqf_pkg::*;
#(
   parameter int CHANNELS     = 8,
   parameter int SAMPLE_WIDTH = 24,
   parameter int DATA_WIDTH   = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [DATA_WIDTH-1:0]      req_tdata,  // sample_in
   input  logic [CHANNEL_WIDTH-1:0]   req_tuser,  // channel
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [DATA_WIDTH-1:0]      rsp_tdata,  // sample_out
   input  logic [CHANNEL_WIDTH:0]     rsp_tuser,  // channel_out, clipped
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_data,
   input  logic                       end_of_run,
   output int                         pending,
   output int                         errors,
   output int                         results_checked,
   output int                         clipped_seen
);

   localparam longint PCM_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint PCM_MIN = -(longint'(1) <<< (SAMPLE_WIDTH - 1));
   localparam int REPORT_LINES = 40;

   typedef struct {
      logic [CHANNEL_WIDTH-1:0]       channel;
      logic signed [SAMPLE_WIDTH-1:0] pcm;
      logic                           clipped;
   } filtered_beat_type;

   logic signed [COEF_WIDTH-1:0] coef_b0;
   logic signed [COEF_WIDTH-1:0] coef_b1;
   logic signed [COEF_WIDTH-1:0] coef_b2;
   logic signed [COEF_WIDTH-1:0] coef_a1;
   logic signed [COEF_WIDTH-1:0] coef_a2;

   logic signed [SAMPLE_WIDTH-1:0] x_prev1 [CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] x_prev2 [CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] y_prev1 [CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] y_prev2 [CHANNELS];

   filtered_beat_type awaited_outputs [$];
   bit                end_checked = 0;

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= REPORT_LINES) begin
         $display("[%0t] filter check: %s", $realtime, what);
      end
   endtask

   // Runs one sample through the direct form I section and advances the
   // history of its channel.
   function automatic filtered_beat_type biquad_step(
                                     input logic [CHANNEL_WIDTH-1:0] ch,
                                     input logic signed [SAMPLE_WIDTH-1:0] x);
      filtered_beat_type beat;
      longint            acc;
      longint            y;
      beat.channel = ch;
      beat.pcm     = '0;
      beat.clipped = 1'b0;
      if (ch < CHANNELS) begin
         acc = longint'(coef_b0) * longint'(x)
             + longint'(coef_b1) * longint'(x_prev1[ch])
             + longint'(coef_b2) * longint'(x_prev2[ch])
             - longint'(coef_a1) * longint'(y_prev1[ch])
             - longint'(coef_a2) * longint'(y_prev2[ch]);
         y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (y > PCM_MAX) begin
            y = PCM_MAX;
            beat.clipped = 1'b1;
         end
         if (y < PCM_MIN) begin
            y = PCM_MIN;
            beat.clipped = 1'b1;
         end
         beat.pcm    = y[SAMPLE_WIDTH-1:0];
         x_prev2[ch] = x_prev1[ch];
         x_prev1[ch] = x;
         y_prev2[ch] = y_prev1[ch];
         y_prev1[ch] = beat.pcm;
      end
      return beat;
   endfunction

   always @(posedge clock) begin
      filtered_beat_type              want;
      logic [CHANNEL_WIDTH-1:0]       got_channel;
      logic signed [SAMPLE_WIDTH-1:0] got_pcm;
      logic                           got_clipped;
      if (reset) begin
         coef_b0 = COEF_WIDTH'(longint'(1) <<< FRAC_BITS);
         coef_b1 = '0;
         coef_b2 = '0;
         coef_a1 = '0;
         coef_a2 = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            x_prev1[i] = '0;
            x_prev2[i] = '0;
            y_prev1[i] = '0;
            y_prev2[i] = '0;
         end
         awaited_outputs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_B0: coef_b0 = csr_data;
               CSR_B1: coef_b1 = csr_data;
               CSR_B2: coef_b2 = csr_data;
               CSR_A1: coef_a1 = csr_data;
               CSR_A2: coef_a2 = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_channel = rsp_tuser[CHANNEL_WIDTH-1:0];
            got_clipped = rsp_tuser[CHANNEL_WIDTH];
            got_pcm     = rsp_tdata[SAMPLE_WIDTH-1:0];
            if (awaited_outputs.size() == 0) begin
               report_mismatch($sformatf("result beat ch %0d pcm %0d with nothing awaited",
                                         got_channel, got_pcm));
            end else begin
               want = awaited_outputs.pop_front();
               results_checked++;
               if (want.clipped) clipped_seen++;
               if (got_channel !== want.channel)
                  report_mismatch($sformatf("channel_out %0d, expected %0d",
                                            got_channel, want.channel));
               if (got_pcm !== want.pcm)
                  report_mismatch($sformatf("ch %0d sample_out %0d, expected %0d",
                                            want.channel, got_pcm, want.pcm));
               if (got_clipped !== want.clipped)
                  report_mismatch($sformatf("ch %0d clipped %b, expected %b",
                                            want.channel, got_clipped, want.clipped));
               if (DATA_WIDTH > SAMPLE_WIDTH && (rsp_tdata >> SAMPLE_WIDTH) !== '0)
                  report_mismatch("padding bits of rsp_tdata are not zero");
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_outputs.push_back(biquad_step(req_tuser, req_tdata[SAMPLE_WIDTH-1:0]));
         end
         if (end_of_run && !end_checked) begin
            end_checked = 1;
            if (awaited_outputs.size() != 0)
               report_mismatch($sformatf("%0d results never arrived", awaited_outputs.size()));
         end
      end
      pending <= awaited_outputs.size();
   end

endmodule

// ===== tb/multichannel_biquad_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Multichannel biquad filter testbench
// Drives interleaved channel samples into the filter under several coefficient
// settings: the reset setting, rounding ties, all-maximum and all-minimum
// coefficients, then random filters. Both sides idle at random, with two quiet
// stretches, one long sink stall and pauses that drain the filter between
// settings. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_tb;
   import mbqf_pkg::*;

   localparam int CHANNELS         = 8;
   localparam int SAMPLE_WIDTH     = 24;
   localparam int DATA_WIDTH       = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RANDOM_SAMPLES   = 800;
   localparam int IDLE_PERCENT     = 16;
   localparam int SINK_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT   = 4000;

   localparam logic [COEF_WIDTH-1:0] COEF_MAX  = COEF_WIDTH'((1 << (COEF_WIDTH - 1)) - 1);
   localparam logic [COEF_WIDTH-1:0] COEF_MIN  = COEF_WIDTH'(1 << (COEF_WIDTH - 1));
   localparam logic [COEF_WIDTH-1:0] COEF_ONE  = COEF_WIDTH'(1 << FRAC_BITS);
   localparam logic [COEF_WIDTH-1:0] COEF_HALF = COEF_WIDTH'(1 << (FRAC_BITS - 1));
   localparam logic [SAMPLE_WIDTH-1:0] PCM_MAX =
      SAMPLE_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic [SAMPLE_WIDTH-1:0] PCM_MIN = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 1));

   typedef enum int {SET_FULL, SET_STABLE, SET_EXTREME, SET_GENTLE} coef_style_type;

   logic                       clock      = 0;
   logic                       reset      = 1;
   logic                       req_tvalid = 0;
   logic                       req_tready;
   logic [DATA_WIDTH-1:0]      req_tdata  = '0;  // sample_in
   logic [CHANNEL_WIDTH-1:0]   req_tuser  = '0;  // channel
   logic                       rsp_tvalid;
   logic                       rsp_tready = 0;
   logic [DATA_WIDTH-1:0]      rsp_tdata;        // sample_out
   logic [CHANNEL_WIDTH:0]     rsp_tuser;        // channel_out, clipped
   logic                       csr_valid  = 0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [COEF_WIDTH-1:0]      csr_data   = '0;

   logic end_of_run = 0;
   logic quiet      = 0;
   logic sink_hold  = 0;
   int   hold_left  = 0;
   int   idle_cycles = 0;
   int   pending;
   int   errors;
   int   results_checked;
   int   clipped_seen;
   int   samples_sent = 0;
   int   settings_used = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   multichannel_biquad_filter #(
      .CHANNELS     (CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   multichannel_biquad_filter_checker #(
      .CHANNELS     (CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DATA_WIDTH   (DATA_WIDTH)
   ) filter_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .end_of_run      (end_of_run),
      .pending         (pending),
      .errors          (errors),
      .results_checked (results_checked),
      .clipped_seen    (clipped_seen)
   );

   // The sink stalls at random and, when asked, holds off for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         rsp_tready <= 1'b0;
      end else begin
         if (sink_hold) begin
            hold_left <= SINK_HOLD_CYCLES;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         rsp_tready <= !sink_hold && hold_left <= 1 &&
                       (quiet || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $realtime, idle_cycles);
            $display("multichannel_biquad_filter_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic send_pcm(input logic [CHANNEL_WIDTH-1:0] ch,
                           input logic [SAMPLE_WIDTH-1:0] pcm);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ch;
      req_tdata  <= DATA_WIDTH'(pcm);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain_filter();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [COEF_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_coefs(input logic [COEF_WIDTH-1:0] b0, b1, b2, a1, a2,
                             input bit with_spares);
      write_csr(CSR_B0, b0);
      write_csr(CSR_B1, b1);
      write_csr(CSR_B2, b2);
      write_csr(CSR_A1, a1);
      write_csr(CSR_A2, a2);
      if (with_spares) begin
         for (int idx = int'(CSR_A2) + 1; idx < (1 << CSR_INDEX_WIDTH); idx++) begin
            write_csr(CSR_INDEX_WIDTH'(idx), COEF_WIDTH'($urandom()));
         end
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [COEF_WIDTH-1:0] coef_within(input int span);
      return COEF_WIDTH'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [COEF_WIDTH-1:0] coef_extreme();
      case ($urandom_range(3))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         default: return COEF_ONE;
      endcase
   endfunction

   function automatic logic [COEF_WIDTH-1:0] pick_coef(input coef_style_type style,
                                                       input int span);
      case (style)
         SET_FULL:    return COEF_WIDTH'($urandom());
         SET_EXTREME: return coef_extreme();
         SET_GENTLE:  return coef_within(1 << (FRAC_BITS - 2));
         default:     return coef_within(span);
      endcase
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_pcm();
      case ($urandom_range(9))
         5, 6, 7: return SAMPLE_WIDTH'(int'($urandom_range(1 << 13)) - (1 << 12));
         8:       return PCM_MAX;
         9:       return PCM_MIN;
         default: return SAMPLE_WIDTH'($urandom());
      endcase
   endfunction

   task automatic random_phase(input int count);
      coef_style_type           style;
      logic [CHANNEL_WIDTH-1:0] ch;
      int                       pick;
      pick = $urandom_range(9);
      style = pick < 2 ? SET_FULL : pick < 6 ? SET_STABLE : pick < 7 ? SET_EXTREME
                                                           : SET_GENTLE;
      load_coefs(pick_coef(style, 1 << FRAC_BITS), pick_coef(style, 1 << FRAC_BITS),
                 pick_coef(style, 1 << FRAC_BITS),
                 pick_coef(style, (1 << (FRAC_BITS + 1)) - (1 << (FRAC_BITS - 2))),
                 pick_coef(style, (1 << FRAC_BITS) - (1 << (FRAC_BITS - 3))),
                 $urandom_range(3) == 0);
      ch = CHANNEL_WIDTH'($urandom_range(CHANNELS - 1));
      repeat (count) begin
         if ($urandom_range(3) != 0) ch = CHANNEL_WIDTH'($urandom_range(CHANNELS - 1));
         send_pcm(ch, pick_pcm());
      end
      drain_filter();
   endtask

   initial begin
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients pass the input straight through.
      send_pcm(3'd0, PCM_MAX);
      send_pcm(3'd1, PCM_MIN);
      send_pcm(3'd2, '0);
      send_pcm(3'd3, '1);
      send_pcm(3'd4, SAMPLE_WIDTH'(1));
      send_pcm(3'd5, 24'h555555);
      send_pcm(3'd6, 24'haaaaaa);
      send_pcm(3'd7, PCM_MAX);
      send_pcm(3'd7, PCM_MIN);
      drain_filter();

      // A gain of one half puts odd inputs exactly on a rounding tie.
      load_coefs(COEF_HALF, '0, '0, '0, '0, 1'b1);
      send_pcm(3'd0, SAMPLE_WIDTH'(1));
      send_pcm(3'd1, '1);
      send_pcm(3'd2, SAMPLE_WIDTH'(3));
      send_pcm(3'd3, SAMPLE_WIDTH'(-3));
      send_pcm(3'd0, PCM_MAX);
      send_pcm(3'd1, PCM_MIN);
      drain_filter();

      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
      send_pcm(3'd0, PCM_MAX);
      send_pcm(3'd1, PCM_MIN);
      send_pcm(3'd0, SAMPLE_WIDTH'(1));
      send_pcm(3'd2, '0);
      drain_filter();

      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
      send_pcm(3'd3, PCM_MAX);
      send_pcm(3'd4, PCM_MIN);
      send_pcm(3'd3, '0);
      send_pcm(3'd5, SAMPLE_WIDTH'(1));
      drain_filter();

      phase = 0;
      while (samples_sent < RANDOM_SAMPLES + 23) begin
         if (phase == 2) begin
            quiet <= 1'b1;
            random_phase(150);
            quiet <= 1'b0;
         end else if (phase == 5) begin
            quiet     <= 1'b1;
            sink_hold <= 1'b1;
            @(posedge clock);
            sink_hold <= 1'b0;
            random_phase(80);
            quiet <= 1'b0;
         end else begin
            random_phase($urandom_range(30, 90));
         end
         phase++;
      end

      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      $display("covered %0d samples on %0d channels under %0d coefficient settings",
               samples_sent, CHANNELS, settings_used + 1);
      $display("checked %0d results, %0d saturated; sink stalled once for %0d cycles",
               results_checked, clipped_seen, SINK_HOLD_CYCLES);
      if (errors == 0) begin
         $display("multichannel_biquad_filter_tb: done, clean");
      end else begin
         $display("multichannel_biquad_filter_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mbqf_pkg.sv
rtl/core/mbqf_ram.sv
rtl/core/mbqf_mac.sv
rtl/core/mbqf_out_queue.sv
rtl/core/multichannel_biquad_filter.sv
tb/multichannel_biquad_filter_checker.sv
tb/multichannel_biquad_filter_tb.sv
